### hw/rtl/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types and constants for the textured wall column shader.
// ----------------------------------------------------------------------------
package tws_pkg;

    // field widths of the stream items
    localparam int TEX_ID_W   = 2;
    localparam int IDX_W      = 12;
    localparam int COLOR_W    = 24;
    localparam int COORD_W    = 12;
    localparam int DIST_W     = 24;
    localparam int TCOL_W     = 6;

    // configuration registers
    localparam int WIDTH_W    = 13;
    localparam int HEIGHT_W   = 13;
    localparam int SCALE_W    = 11;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = SCALE_W + HEIGHT_W;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_SCALE    = 2'd2;

    localparam logic [WIDTH_W-1:0]  SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [HEIGHT_W-1:0] SCREEN_HEIGHT_RST = 13'd480;
    localparam logic [SCALE_W-1:0]  WALL_SCALE_RST    = 11'd64;

    localparam logic [COLOR_W-1:0]  TRANSPARENT_KEY   = 24'h0000FF;

    typedef enum logic
    {
        REQ_LOAD  = 1'b0,
        REQ_SHADE = 1'b1
    } req_t;

    // item context carried down the pipeline
    typedef struct packed
    {
        req_t                kind;
        logic [TEX_ID_W-1:0] tex_id;
        logic [IDX_W-1:0]    texel_index;
        logic [COLOR_W-1:0]  texel_color;
        logic [COORD_W-1:0]  column;
        logic [COORD_W-1:0]  row;
        logic [TCOL_W-1:0]   tex_col;
        logic                mirror;
        logic                ok;
    } item_t;

endpackage

### hw/rtl/tws_div.sv
// ----------------------------------------------------------------------------
// tws_div
// Pipelined restoring divider, one quotient bit per stage, item context
// travels alongside. All stages advance together on en.
// ----------------------------------------------------------------------------
module tws_div
    import tws_pkg::*;
#(
    parameter int DEN_W = 24,
    parameter int Q_W   = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid_in,
    input  item_t            item_in,
    input  logic [DEN_W-1:0] rem_in,
    input  logic [Q_W-1:0]   num_in,
    input  logic [DEN_W-1:0] den_in,
    output logic             valid_out,
    output item_t            item_out,
    output logic [Q_W-1:0]   quo_out
);

    logic             valid_reg [Q_W];
    item_t            item_reg  [Q_W];
    logic [DEN_W-1:0] rem_reg   [Q_W];
    logic [Q_W-1:0]   num_reg   [Q_W];
    logic [Q_W-1:0]   quo_reg   [Q_W];
    logic [DEN_W-1:0] den_reg   [Q_W];

    for (genvar g = 0; g < Q_W; g++)
    begin : g_stage
        logic             valid_src;
        item_t            item_src;
        logic [DEN_W-1:0] rem_src;
        logic [Q_W-1:0]   num_src;
        logic [Q_W-1:0]   quo_src;
        logic [DEN_W-1:0] den_src;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [Q_W-1:0]   quo_next;

        if (g == 0)
        begin : g_first
            assign valid_src = valid_in;
            assign item_src  = item_in;
            assign rem_src   = rem_in;
            assign num_src   = num_in;
            assign quo_src   = '0;
            assign den_src   = den_in;
        end
        else
        begin : g_rest
            assign valid_src = valid_reg[g-1];
            assign item_src  = item_reg[g-1];
            assign rem_src   = rem_reg[g-1];
            assign num_src   = num_reg[g-1];
            assign quo_src   = quo_reg[g-1];
            assign den_src   = den_reg[g-1];
        end

        assign trial    = {rem_src, num_src[Q_W-1]};
        assign ge       = trial >= {1'b0, den_src};
        assign rem_next = ge ? DEN_W'(trial - {1'b0, den_src}) : trial[DEN_W-1:0];
        assign quo_next = Q_W'({quo_src, ge});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g] <= valid_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                item_reg[g] <= item_src;
                rem_reg[g]  <= rem_next;
                num_reg[g]  <= num_src << 1;
                quo_reg[g]  <= quo_next;
                den_reg[g]  <= den_src;
            end
        end
    end

    assign valid_out = valid_reg[Q_W-1];
    assign item_out  = item_reg[Q_W-1];
    assign quo_out   = quo_reg[Q_W-1];

endmodule

### hw/rtl/tws_tex_mem.sv
// ----------------------------------------------------------------------------
// tws_tex_mem
// Texture store: single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module tws_tex_mem
    import tws_pkg::*;
#(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
)
(
    input  logic               clk,
    input  logic               we,
    input  logic               re,
    input  logic [ADDR_W-1:0]  addr,
    input  logic [COLOR_W-1:0] wdata,
    output logic [COLOR_W-1:0] rdata
);

    logic [COLOR_W-1:0] mem [DEPTH];
    logic [COLOR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/textured_wall_column_shader_core.sv
// ----------------------------------------------------------------------------
// textured_wall_column_shader_core
// throughput: one item per cycle while the pipeline is not held by a stalled
//   full output register, set by the one-bit-per-stage height and row dividers
//   and the single texture RAM access stage shared by loads and shades
// reset: valid flags cleared, config registers to 640/480/64; texture RAM
//   contents undefined until loaded, no clearing pass
// ----------------------------------------------------------------------------
module textured_wall_column_shader_core
    import tws_pkg::*;
#(
    parameter int TEX_DIM        = 64,   // power of two
    parameter int TEX_COUNT      = 4,
    parameter int DIST_FRAC_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tex_id, texel_index, texel_color, screen_column, screen_row,
    // hit_distance, tex_column, mirror, zero pad
    input  logic [95:0]           s_tdata,
    // req_type
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pixel_x, pixel_y, pixel_color
    output logic [47:0]           m_tdata
);

    localparam int QB          = $clog2(TEX_DIM);
    localparam int TEX_AREA    = TEX_DIM * TEX_DIM;
    localparam int STORE_DEPTH = TEX_COUNT * TEX_AREA;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int NUM_W       = PROD_W + DIST_FRAC_BITS;
    localparam int PW          = NUM_W + QB;

    // configuration
    logic [WIDTH_W-1:0]  sw_reg;
    logic [HEIGHT_W-1:0] sh_reg;
    logic [SCALE_W-1:0]  scale_reg;
    logic [PROD_W-1:0]   prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg    <= SCREEN_WIDTH_RST;
            sh_reg    <= SCREEN_HEIGHT_RST;
            scale_reg <= WALL_SCALE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SCREEN_WIDTH:  sw_reg    <= cfg_wdata[WIDTH_W-1:0];
                REG_SCREEN_HEIGHT: sh_reg    <= cfg_wdata[HEIGHT_W-1:0];
                REG_WALL_SCALE:    scale_reg <= cfg_wdata[SCALE_W-1:0];
                default:           ;
            endcase
        end
    end

    // numerator base
    assign prod = PROD_W'(scale_reg) * PROD_W'(sh_reg);

    logic adv;

    // input unpack
    item_t             in_item;
    logic [DIST_W-1:0] in_dist;
    logic [DIST_W-1:0] in_den;
    logic [NUM_W-1:0]  in_num;

    always_comb
    begin
        in_item.kind        = req_t'(s_tuser);
        in_item.tex_id      = s_tdata[1:0];
        in_item.texel_index = s_tdata[13:2];
        in_item.texel_color = s_tdata[37:14];
        in_item.column      = s_tdata[49:38];
        in_item.row         = s_tdata[61:50];
        in_item.tex_col     = s_tdata[91:86];
        in_item.mirror      = s_tdata[92];
        in_item.ok          = 1'b0;
        in_dist             = s_tdata[85:62];
        in_den              = (in_dist == '0) ? DIST_W'(1) : in_dist;
        in_num              = NUM_W'(prod) << DIST_FRAC_BITS;
    end

    assign s_tready = adv;

    // wall height H
    logic             hd_valid;
    item_t            hd_item;
    logic [NUM_W-1:0] hd_h;

    tws_div #(
        .DEN_W (DIST_W),
        .Q_W   (NUM_W)
    ) u_height_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid_in  (s_tvalid),
        .item_in   (in_item),
        .rem_in    ('0),
        .num_in    (in_num),
        .den_in    (in_den),
        .valid_out (hd_valid),
        .item_out  (hd_item),
        .quo_out   (hd_h)
    );

    // strip test, clamp and row offset
    logic [HEIGHT_W-1:0] centre;
    logic [HEIGHT_W-1:0] clamp_h;
    logic [HEIGHT_W-1:0] half_l;
    logic [HEIGHT_W-1:0] y_ext;
    logic                in_strip;
    logic                in_bounds;
    logic                id_ok;
    logic                idx_ok;
    logic [NUM_W-1:0]    t_next;
    item_t               a_item_next;

    always_comb
    begin
        centre    = sh_reg >> 1;
        clamp_h   = (hd_h > NUM_W'(sh_reg)) ? sh_reg : hd_h[HEIGHT_W-1:0];
        half_l    = clamp_h >> 1;
        y_ext     = HEIGHT_W'(hd_item.row);
        in_strip  = ((14'(y_ext) + 14'(half_l)) > 14'(centre))
                    && (14'(y_ext) <= (14'(centre) + 14'(half_l)));
        in_bounds = ((WIDTH_W'(hd_item.column) + WIDTH_W'(1)) < sw_reg)
                    && ((y_ext + HEIGHT_W'(1)) < sh_reg);
        id_ok     = 32'(hd_item.tex_id) < 32'(TEX_COUNT);
        idx_ok    = 32'(hd_item.texel_index) < 32'(TEX_AREA);
        t_next    = NUM_W'(y_ext) + (hd_h >> 1) - NUM_W'(centre);

        a_item_next = hd_item;
        if (hd_item.kind == REQ_LOAD)
        begin
            a_item_next.ok = id_ok && idx_ok;
        end
        else
        begin
            a_item_next.ok = id_ok && (hd_h != '0) && in_strip && in_bounds;
        end
    end

    logic             a_valid_reg;
    item_t            a_item_reg;
    logic [NUM_W-1:0] a_h_reg;
    logic [NUM_W-1:0] a_t_reg;
    logic             b_valid_reg;
    item_t            b_item_reg;
    logic [NUM_W-1:0] b_h_reg;
    logic [PW-1:0]    b_p_reg;
    logic [PW-1:0]    b_p_next;

    // t * (TEX_DIM - 1)
    assign b_p_next = (PW'(a_t_reg) << QB) - PW'(a_t_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= hd_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg <= a_item_next;
            a_h_reg    <= hd_h;
            a_t_reg    <= t_next;
            b_item_reg <= a_item_reg;
            b_h_reg    <= a_h_reg;
            b_p_reg    <= b_p_next;
        end
    end

    // texture row
    logic          rd_valid;
    item_t         rd_item;
    logic [QB-1:0] rd_row;

    tws_div #(
        .DEN_W (NUM_W),
        .Q_W   (QB)
    ) u_row_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid_in  (b_valid_reg),
        .item_in   (b_item_reg),
        .rem_in    (b_p_reg[PW-1:QB]),
        .num_in    (b_p_reg[QB-1:0]),
        .den_in    (b_h_reg),
        .valid_out (rd_valid),
        .item_out  (rd_item),
        .quo_out   (rd_row)
    );

    // texture access: loads and shades share this one stage, so every access
    // hits the RAM in arrival order and no forwarding is needed
    logic [QB-1:0]     col;
    logic [ADDR_W-1:0] tex_base;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic              mem_re;
    logic [COLOR_W-1:0] mem_rdata;

    always_comb
    begin
        col      = QB'(rd_item.tex_col);
        if (rd_item.mirror)
        begin
            col = ~col;
        end
        tex_base = ADDR_W'(32'(rd_item.tex_id) * 32'(TEX_AREA));
        if (rd_item.kind == REQ_LOAD)
        begin
            mem_addr = tex_base + ADDR_W'(rd_item.texel_index);
        end
        else
        begin
            mem_addr = tex_base + ADDR_W'({rd_row, col});
        end
        mem_we = adv && rd_valid && rd_item.ok && (rd_item.kind == REQ_LOAD);
        mem_re = adv && rd_valid && rd_item.ok && (rd_item.kind == REQ_SHADE);
    end

    tws_tex_mem #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_tex_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (rd_item.texel_color),
        .rdata (mem_rdata)
    );

    logic               m_valid_reg;
    logic [COORD_W-1:0] m_x_reg;
    logic [COORD_W-1:0] m_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= rd_valid && rd_item.ok && (rd_item.kind == REQ_SHADE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_x_reg <= rd_item.column;
            m_y_reg <= rd_item.row;
        end
    end

    // output register
    logic               produce;
    logic               out_valid_reg;
    logic [COORD_W-1:0] out_x_reg;
    logic [COORD_W-1:0] out_y_reg;
    logic [COLOR_W-1:0] out_color_reg;

    assign produce = m_valid_reg && (mem_rdata != TRANSPARENT_KEY);

    // hold only when a result would land on a stalled full output register
    assign adv = !(out_valid_reg && !m_tready && produce);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= produce;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((!out_valid_reg || m_tready) && produce)
        begin
            out_x_reg     <= m_x_reg;
            out_y_reg     <= m_y_reg;
            out_color_reg <= mem_rdata;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_color_reg, out_y_reg, out_x_reg};

endmodule
